### rtl/bsde_pkg.sv
// Shared types and constants for the button and switch debounce block.
package bsde_pkg;

    // Debounce phase shared by the button and the switch machines.
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_MAYBE     = 2'd1,
        PH_HELD      = 2'd2,
        PH_MAYBE_OFF = 2'd3
    } t_phase;

    // Port pattern with nothing pressed and no switch on.
    localparam logic [7:0] PINS_RELEASED = 8'hFF;

    // Button bit positions (active low).
    localparam int BTN_PRIMARY   = 7;
    localparam int BTN_SECONDARY = 6;
    localparam int BTN_TERTIARY  = 5;
    localparam int BTN_MOVE      = 4;
    localparam int BTN_SCROLL    = 3;

    // Switch bit positions (active low).
    localparam int SW_SENS   = 0;
    localparam int SW_RAPID  = 1;
    localparam int SW_INV_X  = 2;
    localparam int SW_INV_Y  = 3;

    // Click codes.
    localparam logic [7:0] CLICK_NONE          = 8'h00;
    localparam logic [7:0] CLICK_PRESS_PRI     = 8'h80;
    localparam logic [7:0] CLICK_PRESS_SEC     = 8'h40;
    localparam logic [7:0] CLICK_PRESS_TER     = 8'h20;
    localparam logic [7:0] CLICK_RELEASE_PRI   = 8'h01;
    localparam logic [7:0] CLICK_RELEASE_SEC   = 8'h02;
    localparam logic [7:0] CLICK_RELEASE_TER   = 8'h04;

    // Sensitivity shift amounts.
    localparam logic [2:0] SHIFT_NONE   = 3'd0;
    localparam logic [2:0] SHIFT_COARSE = 3'd3;
    localparam logic [2:0] SHIFT_FINE   = 3'd4;

    // Input word: one sample of both ports.
    typedef struct packed {
        logic [7:0] button_pins;
        logic [7:0] switch_pins;
    } t_in_word;

    // Output word: events and settings after one sample.
    typedef struct packed {
        logic       click_valid;
        logic [7:0] click_code;
        logic       move_enable;
        logic       scroll_enable;
        logic       calibrate_request;
        logic       rapid_fire_active;
        logic       rapid_fire_allowed;
        logic [2:0] sensitivity_shift;
        logic       invert_x_neg;
        logic       invert_y_neg;
    } t_out_word;

    // Settings latched by the switch debouncer.
    typedef struct packed {
        logic       rapid_mode;
        logic [2:0] shift_amount;
        logic       negate_x;
        logic       negate_y;
    } t_sw_settings;

    // Results of the button debouncer for one sample.
    typedef struct packed {
        logic [7:0] click_code;
        logic       move_flag;
        logic       scroll_flag;
        logic       calibrate;
        logic       rapid_armed;
    } t_btn_events;

endpackage

### rtl/bsde_btn.sv
// Button debouncer: four-phase machine, click codes and enable toggles.
module bsde_btn (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_button_pins,
    input  logic                  i_rapid_mode,
    output bsde_pkg::t_btn_events o_events
);

    bsde_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_held, n_held;
    logic             r_move, n_move;
    logic             r_scroll, n_scroll;
    logic             r_armed, n_armed;
    logic [7:0]       n_code;
    logic             n_calib;
    logic             same;

    assign same = (i_button_pins == r_held);

    // Next phase.
    always_comb begin
        case (r_phase)
            bsde_pkg::PH_IDLE: begin
                n_phase = (i_button_pins != bsde_pkg::PINS_RELEASED) ?
                          bsde_pkg::PH_MAYBE : bsde_pkg::PH_IDLE;
            end
            bsde_pkg::PH_MAYBE: begin
                n_phase = same ? bsde_pkg::PH_HELD : bsde_pkg::PH_IDLE;
            end
            bsde_pkg::PH_HELD: begin
                n_phase = same ? bsde_pkg::PH_HELD : bsde_pkg::PH_MAYBE_OFF;
            end
            bsde_pkg::PH_MAYBE_OFF: begin
                n_phase = same ? bsde_pkg::PH_HELD : bsde_pkg::PH_IDLE;
            end
            default: begin
                n_phase = bsde_pkg::PH_IDLE;
            end
        endcase
    end

    // Held pattern, click codes, flags and rapid fire.
    always_comb begin
        n_held   = r_held;
        n_move   = r_move;
        n_scroll = r_scroll;
        n_armed  = r_armed;
        n_code   = bsde_pkg::CLICK_NONE;
        n_calib  = 1'b0;
        case (r_phase)
            bsde_pkg::PH_IDLE: begin
                if (i_button_pins != bsde_pkg::PINS_RELEASED) begin
                    n_held = i_button_pins;
                end
            end
            bsde_pkg::PH_MAYBE: begin
                // A confirmed press yields the highest-priority press code; in rapid mode primary arms rapid fire.
                if (same) begin
                    if (!i_button_pins[bsde_pkg::BTN_PRIMARY]) begin
                        if (i_rapid_mode) begin
                            n_armed = 1'b1;
                        end else begin
                            n_code = bsde_pkg::CLICK_PRESS_PRI;
                        end
                    end else if (!i_button_pins[bsde_pkg::BTN_SECONDARY]) begin
                        n_code = bsde_pkg::CLICK_PRESS_SEC;
                    end else if (!i_button_pins[bsde_pkg::BTN_TERTIARY]) begin
                        n_code = bsde_pkg::CLICK_PRESS_TER;
                    end
                end
            end
            bsde_pkg::PH_HELD: begin
                n_held = r_held;
            end
            bsde_pkg::PH_MAYBE_OFF: begin
                // A confirmed release decodes the held pattern.
                if (!same) begin
                    n_held = bsde_pkg::PINS_RELEASED;
                    if (!r_held[bsde_pkg::BTN_PRIMARY]) begin
                        n_code  = bsde_pkg::CLICK_RELEASE_PRI;
                        n_armed = 1'b0;
                    end else if (!r_held[bsde_pkg::BTN_SECONDARY]) begin
                        n_code = bsde_pkg::CLICK_RELEASE_SEC;
                    end else if (!r_held[bsde_pkg::BTN_TERTIARY]) begin
                        n_code = bsde_pkg::CLICK_RELEASE_TER;
                    end else if (!r_held[bsde_pkg::BTN_MOVE]) begin
                        n_move  = ~r_move;
                        n_calib = ~r_move;
                    end else if (!r_held[bsde_pkg::BTN_SCROLL]) begin
                        n_scroll = ~r_scroll;
                        n_calib  = ~r_scroll;
                    end
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    // State registers advance once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bsde_pkg::PH_IDLE;
            r_held   <= bsde_pkg::PINS_RELEASED;
            r_move   <= 1'b0;
            r_scroll <= 1'b0;
            r_armed  <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_move   <= n_move;
            r_scroll <= n_scroll;
            r_armed  <= n_armed;
        end
    end

    assign o_events.click_code  = n_code;
    assign o_events.move_flag   = n_move;
    assign o_events.scroll_flag = n_scroll;
    assign o_events.calibrate   = n_calib;
    assign o_events.rapid_armed = n_armed;

endmodule

### rtl/bsde_sw.sv
// Switch debouncer: four-phase machine that latches the switch settings.
module bsde_sw (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_switch_pins,
    output bsde_pkg::t_sw_settings o_settings_q,
    output bsde_pkg::t_sw_settings o_settings_next
);

    bsde_pkg::t_phase       r_phase, n_phase;
    logic [7:0]             r_held, n_held;
    bsde_pkg::t_sw_settings r_set, n_set;
    bsde_pkg::t_sw_settings decoded;
    logic                   same;

    assign same = (i_switch_pins == r_held);

    // Settings decoded from the current sample.
    always_comb begin
        decoded.shift_amount = i_switch_pins[bsde_pkg::SW_SENS] ?
                               bsde_pkg::SHIFT_COARSE : bsde_pkg::SHIFT_FINE;
        decoded.rapid_mode   = i_switch_pins[bsde_pkg::SW_RAPID];
        decoded.negate_x     = i_switch_pins[bsde_pkg::SW_INV_X];
        decoded.negate_y     = i_switch_pins[bsde_pkg::SW_INV_Y];
    end

    // Next phase.
    always_comb begin
        case (r_phase)
            bsde_pkg::PH_IDLE: begin
                n_phase = same ? bsde_pkg::PH_IDLE : bsde_pkg::PH_MAYBE;
            end
            bsde_pkg::PH_MAYBE: begin
                n_phase = same ? bsde_pkg::PH_HELD : bsde_pkg::PH_IDLE;
            end
            bsde_pkg::PH_HELD: begin
                n_phase = same ? bsde_pkg::PH_HELD : bsde_pkg::PH_MAYBE_OFF;
            end
            bsde_pkg::PH_MAYBE_OFF: begin
                n_phase = same ? bsde_pkg::PH_IDLE : bsde_pkg::PH_HELD;
            end
            default: begin
                n_phase = bsde_pkg::PH_IDLE;
            end
        endcase
    end

    // Held pattern and latched settings.
    always_comb begin
        n_held = r_held;
        n_set  = r_set;
        case (r_phase)
            bsde_pkg::PH_IDLE: begin
                if (!same) begin
                    n_held = i_switch_pins;
                end
            end
            bsde_pkg::PH_MAYBE: begin
                if (same) begin
                    n_set = decoded;
                end
            end
            bsde_pkg::PH_HELD: begin
                if (!same) begin
                    n_held = i_switch_pins;
                end
            end
            bsde_pkg::PH_MAYBE_OFF: begin
                if (same) begin
                    n_set = decoded;
                end
            end
            default: begin
                n_set = r_set;
            end
        endcase
    end

    // State registers advance once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= bsde_pkg::PH_IDLE;
            r_held             <= bsde_pkg::PINS_RELEASED;
            r_set.rapid_mode   <= 1'b0;
            r_set.shift_amount <= bsde_pkg::SHIFT_NONE;
            r_set.negate_x     <= 1'b0;
            r_set.negate_y     <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_set   <= n_set;
        end
    end

    assign o_settings_q    = r_set;
    assign o_settings_next = n_set;

endmodule

### rtl/button_switch_debounce_events.sv
// Top level of the button and switch debounce block with its input and output registers.
//
// Each input word is one sample of eight active-low button pins and eight
// active-low switch pins; each sample gives exactly one output word in order.
// A word passes through an input register, is decoded combinationally by both
// debouncers, and lands in an output register, so the block takes one word per
// cycle while the output is not stalled. The result word is valid at the output
// once it is loaded into the output register, after its sample has been accepted.
// The input side stalls only while the output register holds a word that the
// downstream side is stalling. The button debouncer sees the rapid-fire mode
// in force before the same sample's switch latch. After reset both debouncers
// are idle, all flags are clear and the sensitivity shift reads zero until
// the switches first settle.
module button_switch_debounce_events (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsde_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsde_pkg::t_out_word o_out_word
);

    logic                   r_in_valid;
    bsde_pkg::t_in_word     r_in_word;
    logic                   r_out_valid;
    bsde_pkg::t_out_word    r_out_word;
    bsde_pkg::t_out_word    n_out_word;
    logic                   out_free;
    logic                   step;
    logic                   in_take;
    bsde_pkg::t_btn_events  btn_events;
    bsde_pkg::t_sw_settings sw_q;
    bsde_pkg::t_sw_settings sw_next;

    // Handshake: the output register frees when empty or being taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    bsde_btn u_btn (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_button_pins (r_in_word.button_pins),
        .i_rapid_mode  (sw_q.rapid_mode),
        .o_events      (btn_events)
    );

    bsde_sw u_sw (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_switch_pins   (r_in_word.switch_pins),
        .o_settings_q    (sw_q),
        .o_settings_next (sw_next)
    );

    // Assemble the output word.
    always_comb begin
        n_out_word.click_valid        = (btn_events.click_code != bsde_pkg::CLICK_NONE);
        n_out_word.click_code         = btn_events.click_code;
        n_out_word.move_enable        = btn_events.move_flag;
        n_out_word.scroll_enable      = btn_events.scroll_flag;
        n_out_word.calibrate_request  = btn_events.calibrate;
        n_out_word.rapid_fire_active  = btn_events.rapid_armed;
        n_out_word.rapid_fire_allowed = sw_next.rapid_mode;
        n_out_word.sensitivity_shift  = sw_next.shift_amount;
        n_out_word.invert_x_neg       = sw_next.negate_x;
        n_out_word.invert_y_neg       = sw_next.negate_y;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
